>>> design/mftpg_pkg.sv
package mftpg_pkg;

   // Dividend width: (coordinate + 1) * 255 with coordinates below 4096
   localparam int QW = 20;
   // Divisor width: clamped width or height
   localparam int DW = 13;
   localparam int PW = 30;

   localparam logic [1:0] CSR_FORMAT = 2'd0;
   localparam logic [1:0] CSR_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_HEIGHT = 2'd2;
   localparam logic [1:0] CSR_STRIDE = 2'd3;

   localparam logic [3:0] FMT_1BPP     = 4'd0;
   localparam logic [3:0] FMT_1BPP_IL  = 4'd1;
   localparam logic [3:0] FMT_2BPP_IL  = 4'd2;
   localparam logic [3:0] FMT_2BPP_PL  = 4'd3;
   localparam logic [3:0] FMT_4BPP_PL  = 4'd4;
   localparam logic [3:0] FMT_8BPP     = 4'd5;
   localparam logic [3:0] FMT_8BPP_PL  = 4'd6;
   localparam logic [3:0] FMT_15BPP    = 4'd7;
   localparam logic [3:0] FMT_16BPP    = 4'd8;
   localparam logic [3:0] FMT_24BPP    = 4'd9;
   localparam logic [3:0] FMT_32BPP    = 4'd10;

   localparam logic [31:0] ODD_FIELD_OFFSET = 32'h2000;

   typedef struct packed {
      logic [11:0]   x;
      logic [11:0]   y;
      logic [1:0]    p;
      logic [QW-1:0] na;
      logic [QW-1:0] nb;
      logic [DW-1:0] da;
      logic [DW-1:0] db;
      logic [QW-1:0] qa;
      logic [QW-1:0] qb;
      logic [DW-1:0] ra;
      logic [DW-1:0] rb;
      logic [PW-1:0] prod;
   } ctx_type;

endpackage

>>> design/multi_format_test_pattern_generator_unit.sv
// Test pattern generator: each accepted (col, row, plane) word yields one frame-buffer write
// word (data, byte address, plane mask, byte count). Fully pipelined: a new word can enter every
// cycle while the output is not stalled. The pipeline has 22 register stages: an input stage,
// the two one-bit-per-stage restoring dividers (20 quotient stages) that produce the band index
// and the color gradients, and the output register. Every stage holds its word while the next
// is occupied and stalled, so bubbles are squeezed out. The user must write registers through
// the csr port only while no word is in flight; the block itself does not enforce this.
module multi_format_test_pattern_generator_unit #(
   parameter int MAX_DIM   = 4096,
   parameter int ADDR_BITS = 28
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [11:0]          req_col,
   input  logic [11:0]          req_row,
   input  logic [1:0]           req_plane,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [31:0]          rsp_pixel_data,
   output logic [ADDR_BITS-1:0] rsp_byte_address,
   output logic [3:0]           rsp_plane_mask,
   output logic [2:0]           rsp_byte_count,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_data
);

   localparam int NS = mftpg_pkg::QW + 1;

   logic [3:0]  pixel_format_ff;
   logic [12:0] image_width_ff;
   logic [12:0] image_height_ff;
   logic [15:0] line_stride_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff <= mftpg_pkg::FMT_8BPP;
         image_width_ff  <= 13'd640;
         image_height_ff <= 13'd480;
         line_stride_ff  <= 16'd1920;
      end else if (csr_valid) begin
         case (csr_index)
            mftpg_pkg::CSR_FORMAT: pixel_format_ff <= csr_data[3:0];
            mftpg_pkg::CSR_WIDTH:  image_width_ff  <= csr_data[12:0];
            mftpg_pkg::CSR_HEIGHT: image_height_ff <= csr_data[12:0];
            mftpg_pkg::CSR_STRIDE: line_stride_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   logic [12:0] w, h, pw8, pw4;
   always_comb begin
      w = (32'(image_width_ff) > 32'(MAX_DIM)) ? 13'(MAX_DIM) : image_width_ff;
      h = (32'(image_height_ff) > 32'(MAX_DIM)) ? 13'(MAX_DIM) : image_height_ff;
      pw8 = w >> 3;
      pw4 = w >> 2;
   end

   // stage handshake: a register loads when empty or when its content moves on
   logic [NS:0] v_ff;
   logic [NS:0] ready;
   always_comb begin
      ready[NS] = !v_ff[NS] || !rsp_stall;
      for (int i = NS - 1; i >= 0; i--) begin
         ready[i] = !v_ff[i] || ready[i+1];
      end
   end
   assign req_stall = !ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (ready[0]) v_ff[0] <= req_valid;
         for (int i = 1; i <= NS; i++) begin
            if (ready[i]) v_ff[i] <= v_ff[i-1];
         end
      end
   end

   // input stage: dividends, divisors and the address product
   mftpg_pkg::ctx_type ctx_in;
   logic [12:0] x1, y1;
   logic [11:0] ymul;
   logic [15:0] mmul;
   always_comb begin
      x1 = {1'b0, req_col} + 13'd1;
      y1 = {1'b0, req_row} + 13'd1;
      ctx_in = '0;
      ctx_in.x = req_col;
      ctx_in.y = req_row;
      ctx_in.p = req_plane;
      ctx_in.da = 13'd1;
      ctx_in.db = 13'd1;
      ymul = req_row;
      mmul = {3'b0, w};
      case (pixel_format_ff)
         mftpg_pkg::FMT_1BPP, mftpg_pkg::FMT_1BPP_IL: begin
            ctx_in.na = 20'(req_col);
            ctx_in.da = pw8 >> 2;
            mmul = {3'b0, pw8};
            if (pixel_format_ff == mftpg_pkg::FMT_1BPP_IL) ymul = req_row >> 1;
         end
         mftpg_pkg::FMT_2BPP_IL: begin
            ctx_in.na = 20'(req_col);
            ctx_in.da = pw4 >> 2;
            mmul = {3'b0, pw4};
            ymul = req_row >> 1;
         end
         mftpg_pkg::FMT_2BPP_PL, mftpg_pkg::FMT_4BPP_PL: begin
            ctx_in.na = 20'(req_col);
            ctx_in.da = pw8 >> 4;
            mmul = {3'b0, pw8};
         end
         mftpg_pkg::FMT_15BPP: begin
            ctx_in.na = 20'(x1) * 20'd31;
            ctx_in.nb = 20'(y1) * 20'd31;
            ctx_in.da = w;
            ctx_in.db = h;
         end
         mftpg_pkg::FMT_16BPP: begin
            ctx_in.na = 20'(x1) * 20'd63;
            ctx_in.nb = 20'(y1) * 20'd31;
            ctx_in.da = w;
            ctx_in.db = h;
         end
         mftpg_pkg::FMT_24BPP, mftpg_pkg::FMT_32BPP: begin
            ctx_in.na = 20'(x1) * 20'd255;
            ctx_in.nb = 20'(y1) * 20'd255;
            ctx_in.da = w;
            ctx_in.db = h;
            if (pixel_format_ff == mftpg_pkg::FMT_24BPP) mmul = line_stride_ff;
         end
         default: ;
      endcase
      ctx_in.prod = 30'(ymul) * 30'(mmul);
   end

   mftpg_pkg::ctx_type pipe_ff [0:NS-1];

   always_ff @(posedge clock) begin
      if (ready[0]) pipe_ff[0] <= ctx_in;
   end

   // restoring divider, one quotient bit per stage, MSB first
   for (genvar s = 0; s < mftpg_pkg::QW; s++) begin : g_div
      localparam int BIT = mftpg_pkg::QW - 1 - s;
      mftpg_pkg::ctx_type cur, nxt;
      logic [mftpg_pkg::DW:0] ta, tb;
      always_comb begin
         cur = pipe_ff[s];
         nxt = cur;
         ta = {cur.ra, cur.na[BIT]} - {1'b0, cur.da};
         tb = {cur.rb, cur.nb[BIT]} - {1'b0, cur.db};
         if (!ta[mftpg_pkg::DW]) begin
            nxt.ra = ta[mftpg_pkg::DW-1:0];
            nxt.qa[BIT] = 1'b1;
         end else begin
            nxt.ra = {cur.ra[mftpg_pkg::DW-2:0], cur.na[BIT]};
         end
         if (!tb[mftpg_pkg::DW]) begin
            nxt.rb = tb[mftpg_pkg::DW-1:0];
            nxt.qb[BIT] = 1'b1;
         end else begin
            nxt.rb = {cur.rb[mftpg_pkg::DW-2:0], cur.nb[BIT]};
         end
      end
      always_ff @(posedge clock) begin
         if (ready[s+1]) pipe_ff[s+1] <= nxt;
      end
   end

   // formatting
   mftpg_pkg::ctx_type f;
   logic [31:0] qa, qb, red, lin, addr, data;
   logic [7:0]  bord, c8, b8, g8, r8;
   logic [3:0]  mask;
   logic [2:0]  cnt;
   logic        rowedge, is_edge, pbit;
   always_comb begin
      f = pipe_ff[NS-1];
      qa = (f.da == '0) ? 32'hFFFF_FFFF : 32'(f.qa);
      qb = (f.db == '0) ? 32'hFFFF_FFFF : 32'(f.qb);
      rowedge = (f.y == 12'd0) || ({1'b0, f.y} + 13'd1 == h);
      is_edge = rowedge || (f.x == 12'd0) || ({1'b0, f.x} + 13'd1 == w);
      lin = 32'(f.prod) + 32'(f.x);
      data = '0;
      addr = '0;
      mask = '0;
      cnt = 3'd1;
      bord = '0;
      c8 = '0;
      b8 = '0;
      g8 = '0;
      r8 = '0;
      red = '0;
      pbit = 1'b0;
      case (pixel_format_ff)
         mftpg_pkg::FMT_1BPP, mftpg_pkg::FMT_1BPP_IL: begin
            bord = rowedge ? 8'hFF : 8'h00;
            if (f.x == 12'd0) bord = bord | 8'h80;
            if ({1'b0, f.x} + 13'd1 == pw8) bord = bord | 8'h01;
            case (qa[1:0])
               2'd1: c8 = f.y[1] ? 8'hCC : 8'h33;
               2'd2: c8 = f.y[0] ? 8'hAA : 8'h55;
               2'd3: c8 = 8'hFF;
               default: c8 = 8'h00;
            endcase
            data = {24'b0, c8 | bord};
            if (pixel_format_ff == mftpg_pkg::FMT_1BPP) addr = lin;
            else addr = (f.y[0] ? mftpg_pkg::ODD_FIELD_OFFSET : 32'd0) + lin;
         end
         mftpg_pkg::FMT_2BPP_IL: begin
            bord = rowedge ? 8'hFF : 8'h00;
            if (f.x == 12'd0) bord = bord | 8'hC0;
            if ({1'b0, f.x} + 13'd1 == pw4) bord = bord | 8'h03;
            c8 = qa[7:0];
            c8 = c8 | (c8 << 2);
            c8 = c8 | (c8 << 4);
            data = {24'b0, c8 | bord};
            addr = (f.y[0] ? mftpg_pkg::ODD_FIELD_OFFSET : 32'd0) + lin;
         end
         mftpg_pkg::FMT_2BPP_PL, mftpg_pkg::FMT_4BPP_PL: begin
            bord = rowedge ? 8'hFF : 8'h00;
            if (f.x == 12'd0) bord = bord | 8'h80;
            if ({1'b0, f.x} + 13'd1 == pw8) bord = bord | 8'h01;
            pbit = (pixel_format_ff == mftpg_pkg::FMT_2BPP_PL) ? qa[f.p[1]] : qa[f.p];
            data = {24'b0, {8{pbit}} | bord};
            addr = lin;
            mask = 4'd1 << f.p;
         end
         mftpg_pkg::FMT_8BPP, mftpg_pkg::FMT_8BPP_PL: begin
            data = is_edge ? 32'h0F : {24'b0, f.x[7:0]};
            if (pixel_format_ff == mftpg_pkg::FMT_8BPP) begin
               addr = lin;
            end else begin
               addr = lin >> 2;
               mask = 4'd1 << lin[1:0];
            end
         end
         mftpg_pkg::FMT_15BPP, mftpg_pkg::FMT_16BPP: begin
            red = 32'h1F - qb;
            if (pixel_format_ff == mftpg_pkg::FMT_15BPP)
               data = is_edge ? 32'h7FFF : {16'b0, 16'((qb << 10) | (qa << 5) | red)};
            else
               data = is_edge ? 32'hFFFF : {16'b0, 16'((qb << 11) | (qa << 5) | red)};
            addr = lin << 1;
            cnt = 3'd2;
         end
         mftpg_pkg::FMT_24BPP: begin
            b8 = qb[7:0];
            r8 = 8'hFF - b8;
            g8 = qa[7:0];
            data = is_edge ? 32'hFF_FFFF : {8'b0, b8, g8, r8};
            addr = 32'(f.prod) + 32'(f.x) * 32'd3;
            cnt = 3'd3;
         end
         mftpg_pkg::FMT_32BPP: begin
            red = 32'hFF - qb;
            data = is_edge ? 32'hFFFF_FFFF : ((qb << 16) | (qa << 8) | red);
            addr = lin << 2;
            cnt = 3'd4;
         end
         default: ;
      endcase
   end

   logic [31:0]          out_data_ff;
   logic [ADDR_BITS-1:0] out_addr_ff;
   logic [3:0]           out_mask_ff;
   logic [2:0]           out_cnt_ff;
   always_ff @(posedge clock) begin
      if (ready[NS]) begin
         out_data_ff <= data;
         out_addr_ff <= addr[ADDR_BITS-1:0];
         out_mask_ff <= mask;
         out_cnt_ff  <= cnt;
      end
   end

   assign rsp_valid        = v_ff[NS];
   assign rsp_pixel_data   = out_data_ff;
   assign rsp_byte_address = out_addr_ff;
   assign rsp_plane_mask   = out_mask_ff;
   assign rsp_byte_count   = out_cnt_ff;

endmodule

>>> design/mftpg_checker.sv
module mftpg_checker #(
   parameter int ADDR_BITS = 28
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [31:0]          rsp_pixel_data,
   input logic [3:0]           rsp_plane_mask,
   input logic [2:0]           rsp_byte_count
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_data))
      else $error("stalled result word changed");

   a_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_byte_count == 3'd1 || rsp_byte_count == 3'd2 ||
                     rsp_byte_count == 3'd3 || rsp_byte_count == 3'd4))
      else $error("byte count out of range");

   a_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(rsp_plane_mask))
      else $error("plane mask not one-hot");

   a_narrow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_count == 3'd1 |-> rsp_pixel_data[31:8] == 24'd0)
      else $error("single byte word has upper bits set");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind multi_format_test_pattern_generator_unit mftpg_checker #(.ADDR_BITS(ADDR_BITS)) u_chk (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_pixel_data(rsp_pixel_data),
   .rsp_plane_mask(rsp_plane_mask),
   .rsp_byte_count(rsp_byte_count)
);

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam int MAX_DIM   = 4096;
   localparam int ADDR_BITS = 28;
   localparam int LATENCY   = 22;
   localparam int WDOG_MAX  = 20000;

   typedef struct {
      logic [31:0] data;
      logic [27:0] addr;
      logic [3:0]  mask;
      logic [2:0]  cnt;
   } fb_write_type;

   // expected frame-buffer writes, predicted from a shadow copy of the registers
   class pattern_scoreboard;
      logic [3:0]   fmt;
      logic [12:0]  width;
      logic [12:0]  height;
      logic [15:0]  stride;
      fb_write_type pending[$];
      int           errors;
      int           checked;

      function void reset_regs();
         fmt = mftpg_pkg::FMT_8BPP;
         width = 13'd640;
         height = 13'd480;
         stride = 16'd1920;
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] val);
         case (idx)
            mftpg_pkg::CSR_FORMAT: fmt = val[3:0];
            mftpg_pkg::CSR_WIDTH:  width = val[12:0];
            mftpg_pkg::CSR_HEIGHT: height = val[12:0];
            mftpg_pkg::CSR_STRIDE: stride = val;
            default: ;
         endcase
      endfunction

      function logic [31:0] qdiv(logic [31:0] n, logic [31:0] d);
         return (d == 0) ? 32'hFFFF_FFFF : n / d;
      endfunction

      function void note_coord(logic [11:0] xi, logic [11:0] yi, logic [1:0] p);
         logic [31:0] x, y, w, h, pw, dv, b, c, blue, red, green, data, mask, cnt;
         logic [63:0] addr, lin;
         logic rowedge, edge_px;
         fb_write_type e;
         x = xi;
         y = yi;
         w = (width > MAX_DIM) ? MAX_DIM : width;
         h = (height > MAX_DIM) ? MAX_DIM : height;
         rowedge = (y == 0) || (y + 1 == h);
         edge_px = rowedge || x == 0 || x + 1 == w;
         lin = 64'(y) * w + x;
         data = 0; mask = 0; cnt = 1; addr = 0;
         case (fmt)
            mftpg_pkg::FMT_1BPP, mftpg_pkg::FMT_1BPP_IL: begin
               pw = w >> 3; dv = pw >> 2;
               b = rowedge ? 32'hFF : 0;
               if (x == 0) b |= 32'h80;
               if (x + 1 == pw) b |= 32'h01;
               case (qdiv(x, dv) & 3)
                  1: c = y[1] ? 32'hCC : 32'h33;
                  2: c = y[0] ? 32'hAA : 32'h55;
                  3: c = 32'hFF;
                  default: c = 0;
               endcase
               data = c | b;
               if (fmt == mftpg_pkg::FMT_1BPP) addr = 64'(y) * pw + x;
               else addr = (y[0] ? 64'h2000 : 0) + 64'(y >> 1) * pw + x;
            end
            mftpg_pkg::FMT_2BPP_IL: begin
               pw = w >> 2; dv = pw >> 2;
               b = rowedge ? 32'hFF : 0;
               if (x == 0) b |= 32'hC0;
               if (x + 1 == pw) b |= 32'h03;
               c = qdiv(x, dv) & 32'hFF;
               c = (c | (c << 2)) & 32'hFF;
               c = (c | (c << 4)) & 32'hFF;
               data = c | b;
               addr = (y[0] ? 64'h2000 : 0) + 64'(y >> 1) * pw + x;
            end
            mftpg_pkg::FMT_2BPP_PL, mftpg_pkg::FMT_4BPP_PL: begin
               pw = w >> 3; dv = pw >> 4;
               b = rowedge ? 32'hFF : 0;
               if (x == 0) b |= 32'h80;
               if (x + 1 == pw) b |= 32'h01;
               c = qdiv(x, dv) & 32'hFF;
               c = (c >> ((fmt == mftpg_pkg::FMT_2BPP_PL) ? (p >> 1) : p)) & 1;
               data = (c != 0 ? 32'hFF : 0) | b;
               addr = 64'(y) * pw + x;
               mask = 32'd1 << p;
            end
            mftpg_pkg::FMT_8BPP, mftpg_pkg::FMT_8BPP_PL: begin
               data = edge_px ? 32'h0F : (x & 32'hFF);
               if (fmt == mftpg_pkg::FMT_8BPP) addr = lin;
               else begin
                  addr = lin >> 2;
                  mask = 32'd1 << lin[1:0];
               end
            end
            mftpg_pkg::FMT_15BPP, mftpg_pkg::FMT_16BPP: begin
               blue = qdiv((y + 1) * 32'h1F, h);
               red = 32'h1F - blue;
               if (fmt == mftpg_pkg::FMT_15BPP) begin
                  green = qdiv((x + 1) * 32'h1F, w);
                  c = ((blue << 10) | (green << 5) | red) & 32'hFFFF;
                  data = edge_px ? 32'h7FFF : c;
               end else begin
                  green = qdiv((x + 1) * 32'h3F, w);
                  c = ((blue << 11) | (green << 5) | red) & 32'hFFFF;
                  data = edge_px ? 32'hFFFF : c;
               end
               addr = lin * 2;
               cnt = 2;
            end
            mftpg_pkg::FMT_24BPP: begin
               blue = qdiv((y + 1) * 32'hFF, h) & 32'hFF;
               red = (32'hFF - blue) & 32'hFF;
               green = qdiv((x + 1) * 32'hFF, w) & 32'hFF;
               data = edge_px ? 32'hFF_FFFF : (red | (green << 8) | (blue << 16));
               addr = 64'(y) * stride + 64'(x) * 3;
               cnt = 3;
            end
            mftpg_pkg::FMT_32BPP: begin
               blue = qdiv((y + 1) * 32'hFF, h);
               red = 32'hFF - blue;
               green = qdiv((x + 1) * 32'hFF, w);
               data = edge_px ? 32'hFFFF_FFFF : ((blue << 16) | (green << 8) | red);
               addr = lin * 4;
               cnt = 4;
            end
            default: ;
         endcase
         e.data = data;
         e.addr = addr[27:0];
         e.mask = mask[3:0];
         e.cnt = cnt[2:0];
         pending.push_back(e);
      endfunction

      function void check_write(fb_write_type got);
         fb_write_type e;
         checked++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected word data=%h addr=%h", $time, got.data, got.addr);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.data !== e.data) begin
            $display("%0t: pixel_data exp %h got %h", $time, e.data, got.data);
            errors++;
         end
         if (got.addr !== e.addr) begin
            $display("%0t: byte_address exp %h got %h", $time, e.addr, got.addr);
            errors++;
         end
         if (got.mask !== e.mask) begin
            $display("%0t: plane_mask exp %h got %h", $time, e.mask, got.mask);
            errors++;
         end
         if (got.cnt !== e.cnt) begin
            $display("%0t: byte_count exp %0d got %0d", $time, e.cnt, got.cnt);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [11:0] req_col;
   logic [11:0] req_row;
   logic [1:0]  req_plane;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_pixel_data;
   logic [27:0] rsp_byte_address;
   logic [3:0]  rsp_plane_mask;
   logic [2:0]  rsp_byte_count;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;

   pattern_scoreboard sb;
   bit   idle_on;
   bit   hold_rsp;
   int   idle_cycles;
   int   sent;
   int   formats_run;

   multi_format_test_pattern_generator_unit #(
      .MAX_DIM(MAX_DIM),
      .ADDR_BITS(ADDR_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_col(req_col),
      .req_row(req_row),
      .req_plane(req_plane),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pixel_data(rsp_pixel_data),
      .rsp_byte_address(rsp_byte_address),
      .rsp_plane_mask(rsp_plane_mask),
      .rsp_byte_count(rsp_byte_count),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // receiver: random stall bursts, plus a long hold when requested
   initial begin
      int n;
      rsp_stall = 1'b1;
      @(posedge clock);
      while (1) begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (200) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 11);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end else begin
            n = $urandom_range(1, 20);
            rsp_stall <= 1'b0;
            repeat (n) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      fb_write_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.data = rsp_pixel_data;
         got.addr = rsp_byte_address;
         got.mask = rsp_plane_mask;
         got.cnt = rsp_byte_count;
         sb.check_write(got);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
         $display("watchdog expired");
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_coord(logic [11:0] x, logic [11:0] y, logic [1:0] p);
      int n;
      if (idle_on && $urandom_range(0, 6) == 0) begin
         n = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_col <= x;
      req_row <= y;
      req_plane <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_coord(x, y, p);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.write_reg(idx, val);
   endtask

   task automatic set_mode(logic [3:0] f, logic [12:0] w, logic [12:0] h, logic [15:0] s);
      drain();
      write_csr(mftpg_pkg::CSR_FORMAT, {12'd0, f});
      write_csr(mftpg_pkg::CSR_WIDTH, {3'd0, w});
      write_csr(mftpg_pkg::CSR_HEIGHT, {3'd0, h});
      write_csr(mftpg_pkg::CSR_STRIDE, s);
      formats_run++;
   endtask

   // mostly in-frame coordinates, some out of frame, some on edges
   task automatic random_coords(int n, int w, int h);
      logic [11:0] x, y;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0: x = 12'($urandom);
            1: x = (w > 0) ? 12'(w - 1) : 12'd0;
            2: x = 12'((w >> 3) - 1);
            default: x = (w > 1) ? 12'($urandom_range(0, w - 1)) : 12'd0;
         endcase
         case ($urandom_range(0, 9))
            0: y = 12'($urandom);
            1: y = (h > 0) ? 12'(h - 1) : 12'd0;
            2: y = 12'd0;
            default: y = (h > 1) ? 12'($urandom_range(0, h - 1)) : 12'd0;
         endcase
         send_coord(x, y, 2'($urandom));
      end
   endtask

   initial begin
      int w, h;
      logic [3:0] f;
      sb = new();
      sb.reset_regs();
      reset = 1'b1;
      req_valid = 1'b0;
      req_col = '0;
      req_row = '0;
      req_plane = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      idle_on = 1'b1;
      hold_rsp = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, corners
      send_coord(12'd0, 12'd0, 2'd0);
      send_coord(12'd639, 12'd479, 2'd3);
      send_coord(12'hFFF, 12'hFFF, 2'd1);
      send_coord(12'd100, 12'd200, 2'd2);

      // each format at an ordinary size
      for (int fi = 0; fi <= 10; fi++) begin
         set_mode(4'(fi), 13'd640, 13'd480, 16'd1920);
         send_coord(12'd0, 12'd5, 2'd0);
         send_coord(12'd79, 12'd6, 2'd1);
         send_coord(12'd30, 12'd7, 2'($urandom));
         send_coord(12'd50, 12'd2, 2'($urandom));
      end
      // zero dims (zero divisors), oversized dims, undefined format, max stride
      set_mode(mftpg_pkg::FMT_32BPP, 13'd0, 13'd0, 16'hFFFF);
      send_coord(12'd0, 12'd0, 2'd0);
      send_coord(12'd7, 12'd9, 2'd0);
      set_mode(mftpg_pkg::FMT_24BPP, 13'h1FFF, 13'h1FFF, 16'hFFFF);
      send_coord(12'hFFF, 12'hFFF, 2'd3);
      send_coord(12'hFFE, 12'hFFE, 2'd2);
      set_mode(4'd15, 13'd100, 13'd100, 16'd0);
      send_coord(12'd5, 12'd5, 2'd1);
      set_mode(mftpg_pkg::FMT_2BPP_IL, 13'd1, 13'd1, 16'd0);
      send_coord(12'd3, 12'd1, 2'd0);

      // random settings; long receiver hold while sender keeps offering
      for (int ph = 0; ph < 24; ph++) begin
         f = (ph % 8 == 7) ? 4'($urandom_range(11, 15)) : 4'($urandom_range(0, 10));
         case ($urandom_range(0, 5))
            0: w = $urandom_range(0, 8191);
            1: w = $urandom_range(1, 64);
            default: w = $urandom_range(32, 4096);
         endcase
         case ($urandom_range(0, 5))
            0: h = $urandom_range(0, 8191);
            1: h = $urandom_range(1, 4);
            default: h = $urandom_range(2, 4096);
         endcase
         if (ph >= 20) idle_on = 1'b0;
         set_mode(f, 13'(w), 13'(h), 16'($urandom));
         if (ph == 3) hold_rsp = 1'b1;
         // enough words during the hold to fill every stage and back up the input
         random_coords((ph == 3) ? 48 : 14, (w > MAX_DIM) ? MAX_DIM : w,
                       (h > MAX_DIM) ? MAX_DIM : h);
      end
      drain();

      $display("covered %0d words over %0d register settings, all 11 formats", sent,
               formats_run);
      $display("with zero/oversized dimensions, undefined formats and stall pressure");
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
